@@ design/assert_macros.svh @@
// Assertion helpers for the Modbus slave block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a second one in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Check that a condition implies a second one in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ design/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types and constants of the Modbus RTU register slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_TX_SLOT = 2'd2;
  localparam logic [1:0] FUNC_ANALOG  = 2'd3;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_WE_ZERO    = 2'd1;
  localparam logic [1:0] CFG_WE_ONE     = 2'd2;
  localparam logic [1:0] CFG_GAP        = 2'd3;

  localparam logic [7:0]  MB_FN_READ  = 8'd3;
  localparam logic [7:0]  MB_FN_WRITE = 8'd16;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] UNMAPPED    = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [2:0]  analog_index;
    logic [15:0] analog_value;
  } in_item_t;

  typedef struct packed {
    logic        event_res;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [15:0] dac_zero_value;
    logic [15:0] dac_one_value;
  } out_item_t;

  // Start strobe and data byte from sequencer to CRC unit
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } crc_req_t;

endpackage

@@ design/mbrtu_if.sv @@
// ----------------------------------------------------------------------------
// mbrtu_in_if / mbrtu_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbrtu_in_if;
  logic               valid;
  logic               ready;
  mbrtu_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mbrtu_out_if;
  logic                valid;
  logic                ready;
  mbrtu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/mbrtu_crc.sv @@
// ----------------------------------------------------------------------------
// mbrtu_crc
// Bit-serial CRC-16 unit: one shift of the reflected polynomial per cycle unless init or start comes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbrtu_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbrtu_pkg::crc_req_t req_i,
  input  logic                init_i,
  output logic                busy_o,
  output logic [15:0]         crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;

  // Load the seed on init; on start fold the byte in, then shift eight times
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (init_i) begin
      crc_d = mbrtu_pkg::CRC_INIT;
      cnt_d = 4'd0;
    end else if (req_i.start) begin
      crc_d = crc_q ^ {8'd0, req_i.data};
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ mbrtu_pkg::CRC_POLY) : (crc_q >> 1);
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= mbrtu_pkg::CRC_INIT;
      cnt_q <= 4'd0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign crc_o  = crc_q;

endmodule

@@ design/modbus_rtu_register_slave_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_top
// Modbus RTU slave: frame store, CRC check, register read and DAC write.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload
// in_ch    | in  | func, rx_byte, analog_index, analog_value
// out_ch   | out | event_res, tx_byte, last_byte, dac_zero_value, dac_one_value
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// A received byte and a transmitted frame byte wait on the bit-serial CRC unit;
// CRC bytes, the end event, ticks and analog updates do not feed it. Frame end
// walks the frame buffer through its single port, for a read and for a write.
// Reset clears all control state; the frame buffer is not cleared. The input
// is not ready while an item is in work or a result waits on the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modbus_rtu_register_slave_top #(
  parameter int BUFFER_DEPTH  = 128,
  parameter int MAX_READ_REGS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = 10;

  typedef enum logic [4:0] {
    S_IDLE, S_RX_CRC, S_TICK, S_FE_RD0, S_FE_RD1, S_FE_RD2, S_FE_RD3, S_FE_RD5,
    S_FE_DEC, S_RD_HI, S_RD_LO, S_WR_RHI, S_WR_RLO, S_WR_APPLY, S_TX_FIRST,
    S_TX_RD, S_TX_CRC, S_OUT
  } state_e;

  state_e          state_q;
  logic [1:0]      phase_q;   // 0 idle, 1 rx, 2 tx
  logic [PW-1:0]   pos_q;
  logic [PW-1:0]   rlen_q;
  logic [7:0]      gap_q;
  logic [7:0]      addr_cfg_q, we0_q, we1_q, gap_cfg_q;
  logic [15:0]     ana_q [8];
  logic [15:0]     dac_q [2];
  logic [7:0]      mem [BUFFER_DEPTH];
  logic [7:0]      rdat_q;
  logic [7:0]      fn_q, cnt_q, b0_q, hi_q;
  logic [15:0]     adr_q;
  logic [7:0]      j_q;
  logic [PW-1:0]   ptr_q;
  logic            crc_ok_q;
  mbrtu_pkg::out_item_t res_q;
  logic            res_v_q;

  // Shared buffer port, driven from the sequencer
  logic            m_we;
  logic [PW-1:0]   m_addr;
  logic [7:0]      m_wdat;
  mbrtu_pkg::crc_req_t crc_req;
  logic            crc_init, crc_busy;
  logic [15:0]     crc_val;
  logic [15:0]     map_v;
  logic [15:0]     cur_adr;

  mbrtu_crc u_crc (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(crc_req), .init_i(crc_init),
    .busy_o(crc_busy), .crc_o(crc_val)
  );

  function automatic logic in_buf(input logic [PW-1:0] a);
    return a < PW'(BUFFER_DEPTH);
  endfunction

  // Buffer memory with registered read; out-of-range reads give zero
  always_ff @(posedge clk_i) begin
    if (m_we && in_buf(m_addr)) mem[AW'(m_addr)] <= m_wdat;
    rdat_q <= in_buf(m_addr) ? mem[AW'(m_addr)] : 8'd0;
  end

  // Register map read
  assign cur_adr = adr_q + {8'd0, j_q};
  always_comb begin
    if (cur_adr <= 16'd3)       map_v = ana_q[cur_adr[1:0]];
    else if (cur_adr <= 16'd5)  map_v = dac_q[cur_adr[0]];
    else if (cur_adr == 16'd6)  map_v = {8'd0, we0_q};
    else if (cur_adr == 16'd7)  map_v = {8'd0, we1_q};
    else if (cur_adr <= 16'd11) map_v = ana_q[cur_adr[2:0] - 3'd4];
    else                        map_v = mbrtu_pkg::UNMAPPED;
  end

  // Sequencer combinational controls for memory and CRC
  always_comb begin
    m_we = 1'b0; m_addr = ptr_q; m_wdat = 8'd0;
    crc_req = '0; crc_init = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready && in_ch.data.func == mbrtu_pkg::FUNC_RX_BYTE
            && phase_q != 2'd2 && in_buf(pos_q)) begin
          m_we = 1'b1; m_addr = pos_q; m_wdat = in_ch.data.rx_byte;
          crc_req.start = 1'b1; crc_req.data = in_ch.data.rx_byte;
        end
      end
      S_FE_DEC: begin
        crc_init = 1'b1;
        // Store the byte count only for an accepted read
        if (fn_q == mbrtu_pkg::MB_FN_READ && b0_q == addr_cfg_q && crc_ok_q
            && rdat_q <= 8'(MAX_READ_REGS)) begin
          m_we = 1'b1; m_addr = PW'(2); m_wdat = {rdat_q[6:0], 1'b0};
        end
      end
      S_RD_HI: begin
        m_we = 1'b1; m_addr = ptr_q; m_wdat = map_v[15:8];
      end
      S_RD_LO: begin
        m_we = 1'b1; m_addr = ptr_q; m_wdat = map_v[7:0];
      end
      S_TX_FIRST: begin
        crc_req.start = 1'b1; crc_req.data = b0_q;
      end
      S_TX_CRC: begin
        crc_req.start = 1'b1; crc_req.data = rdat_q;
      end
      S_OUT: begin
        if (res_q.event_res) crc_init = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_q == S_IDLE) && !res_v_q;
  assign out_ch.valid = res_v_q;
  assign out_ch.data  = res_q;

  // Sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= 2'd0; pos_q <= '0; rlen_q <= '0;
      gap_q <= 8'd0; addr_cfg_q <= 8'd1; we0_q <= 8'd0; we1_q <= 8'd0;
      gap_cfg_q <= 8'd90; res_v_q <= 1'b0;
      for (int i = 0; i < 8; i++) ana_q[i] <= 16'd0;
      dac_q[0] <= 16'd0; dac_q[1] <= 16'd0;
      ptr_q <= '0; j_q <= 8'd0; crc_ok_q <= 1'b0;
      fn_q <= 8'd0; cnt_q <= 8'd0; b0_q <= 8'd0; hi_q <= 8'd0; adr_q <= 16'd0;
      res_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mbrtu_pkg::CFG_SLAVE_ADDR: addr_cfg_q <= cfg_data_i;
          mbrtu_pkg::CFG_WE_ZERO:    we0_q      <= cfg_data_i;
          mbrtu_pkg::CFG_WE_ONE:     we1_q      <= cfg_data_i;
          mbrtu_pkg::CFG_GAP:        gap_cfg_q  <= cfg_data_i;
        endcase
      end
      if (out_ch.valid && out_ch.ready) res_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            unique case (in_ch.data.func)
              mbrtu_pkg::FUNC_RX_BYTE: begin
                if (phase_q != 2'd2) begin
                  phase_q <= 2'd1; gap_q <= 8'd0;
                  if (in_buf(pos_q)) begin
                    pos_q <= pos_q + 1'b1; state_q <= S_RX_CRC;
                  end
                end
              end
              mbrtu_pkg::FUNC_TICK: state_q <= S_TICK;
              mbrtu_pkg::FUNC_TX_SLOT: begin
                if (phase_q == 2'd2) begin
                  pos_q <= pos_q + 1'b1; ptr_q <= pos_q + 1'b1;
                  state_q <= S_TX_RD;
                end
              end
              mbrtu_pkg::FUNC_ANALOG: ana_q[in_ch.data.analog_index] <= in_ch.data.analog_value;
            endcase
          end
        end
        S_RX_CRC: if (!crc_busy) state_q <= S_IDLE;
        S_TICK: begin
          state_q <= S_IDLE;
          if (phase_q == 2'd1) begin
            if ((gap_q == 8'hFF ? gap_q : gap_q + 8'd1) >= gap_cfg_q) begin
              crc_ok_q <= (crc_val == 16'd0);
              ptr_q <= PW'(0); state_q <= S_FE_RD0;
              phase_q <= 2'd0; gap_q <= 8'd0; pos_q <= '0;
            end else if (gap_q != 8'hFF) gap_q <= gap_q + 8'd1;
          end
        end
        S_FE_RD0: begin ptr_q <= PW'(1); state_q <= S_FE_RD1; end
        S_FE_RD1: begin b0_q <= rdat_q; ptr_q <= PW'(2); state_q <= S_FE_RD2; end
        S_FE_RD2: begin fn_q <= rdat_q; ptr_q <= PW'(3); state_q <= S_FE_RD3; end
        S_FE_RD3: begin adr_q[15:8] <= rdat_q; ptr_q <= PW'(5); state_q <= S_FE_RD5; end
        S_FE_RD5: begin adr_q[7:0] <= rdat_q; state_q <= S_FE_DEC; end
        S_FE_DEC: begin
          cnt_q <= rdat_q; j_q <= 8'd0;
          if (b0_q != addr_cfg_q || !crc_ok_q) state_q <= S_IDLE;
          else if (fn_q == mbrtu_pkg::MB_FN_READ) begin
            if (rdat_q > 8'(MAX_READ_REGS)) state_q <= S_IDLE;
            else begin
              ptr_q <= PW'(3); rlen_q <= PW'(3) + PW'({rdat_q, 1'b0});
              state_q <= (rdat_q == 8'd0) ? S_TX_FIRST : S_RD_HI;
            end
          end else if (fn_q == mbrtu_pkg::MB_FN_WRITE) begin
            ptr_q <= PW'(7); rlen_q <= PW'(6);
            state_q <= (rdat_q == 8'd0) ? S_TX_FIRST : S_WR_RHI;
          end else state_q <= S_IDLE;
        end
        S_RD_HI: begin ptr_q <= ptr_q + 1'b1; state_q <= S_RD_LO; end
        S_RD_LO: begin
          ptr_q <= ptr_q + 1'b1; j_q <= j_q + 8'd1;
          state_q <= (j_q + 8'd1 == cnt_q) ? S_TX_FIRST : S_RD_HI;
        end
        S_WR_RHI: begin ptr_q <= ptr_q + 1'b1; state_q <= S_WR_RLO; end
        S_WR_RLO: begin hi_q <= rdat_q; ptr_q <= ptr_q + 1'b1; state_q <= S_WR_APPLY; end
        S_WR_APPLY: begin
          if (cur_adr == 16'd4 && we0_q != 8'd0) dac_q[0] <= {hi_q, rdat_q};
          if (cur_adr == 16'd5 && we1_q != 8'd0) dac_q[1] <= {hi_q, rdat_q};
          j_q <= j_q + 8'd1;
          state_q <= (j_q + 8'd1 == cnt_q) ? S_TX_FIRST : S_WR_RHI;
        end
        S_TX_FIRST: begin
          phase_q <= 2'd2;
          res_q <= '{1'b0, b0_q, 1'b0, dac_q[0], dac_q[1]};
          state_q <= S_OUT;
        end
        S_TX_RD: begin
          if (pos_q < rlen_q) state_q <= S_TX_CRC;
          else begin
            if (pos_q == rlen_q)
              res_q <= '{1'b0, crc_val[7:0], 1'b0, dac_q[0], dac_q[1]};
            else if (pos_q == rlen_q + 1'b1)
              res_q <= '{1'b0, crc_val[15:8], 1'b1, dac_q[0], dac_q[1]};
            else begin
              res_q <= '{1'b1, 8'd0, 1'b0, dac_q[0], dac_q[1]};
              pos_q <= '0; phase_q <= 2'd0;
            end
            state_q <= S_OUT;
          end
        end
        S_TX_CRC: begin
          res_q <= '{1'b0, rdat_q, 1'b0, dac_q[0], dac_q[1]};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!crc_busy) begin res_v_q <= 1'b1; state_q <= S_IDLE; end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ch.ready, state_q == S_IDLE)
  `ASSERT_IMPL(a_no_tx_rx, clk_i, rst_ni, state_q == S_RX_CRC, phase_q == 2'd1)
  `ASSERT_NEXT(a_out_set, clk_i, rst_ni, state_q == S_OUT && !crc_busy, res_v_q)

endmodule
